// ===== hdl/sdl_pkg.sv =====
// Shared constants, control struct and state encoding for the sign-data LMS filter.
`timescale 1ns / 1ps

package sdl_pkg;

	localparam int DATA_W       = 16;
	localparam int COEF_W       = 32;
	localparam int PROD_W       = DATA_W + COEF_W;
	localparam int STEP_W       = 16;
	localparam int DELTA_W      = 30;
	localparam int Y_SHIFT      = 28;
	localparam int TAPS_DEFAULT = 32;

	localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;
	localparam logic [DATA_W-1:0] DATA_MAX   = 16'h7fff;
	localparam logic [DATA_W-1:0] DATA_MIN   = 16'h8000;
	localparam logic [COEF_W-1:0] COEF_MAX   = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] COEF_MIN   = 32'h8000_0000;

	typedef struct packed {
		logic start;
		logic mac_rd;
		logic fin_y;
		logic fin_e;
		logic fin_d;
		logic upd_rd;
		logic load_out;
	} dp_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_FIN_Y,
		ST_FIN_E,
		ST_FIN_D,
		ST_UPD,
		ST_UPD_END,
		ST_OUT
	} state_t;

endpackage

// ===== hdl/sdl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module sdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/sdl_dp.sv =====
// Datapath: shared multiply-accumulate, output rounding, error, step and coefficient update.
`timescale 1ns / 1ps

module sdl_dp
	import sdl_pkg::*;
#(
	parameter int TAPS = TAPS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dp_ctl_t                             ctl,
	input  logic signed [DATA_W-1:0]            desired,
	input  logic [STEP_W-1:0]                   step_size,
	input  logic [DATA_W-1:0]                   samp_rdata,
	input  logic [COEF_W-1:0]                   coef_rdata,
	input  logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] rd_idx,
	output logic                                mac_busy,
	output logic                                coef_we,
	output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] coef_waddr,
	output logic [COEF_W-1:0]                   coef_wdata,
	output logic signed [DATA_W-1:0]            error_out,
	output logic signed [DATA_W-1:0]            filter_out
);

	localparam int AW    = TAPS > 1 ? $clog2(TAPS) : 1;
	localparam int ACC_W = PROD_W + AW + 1;
	localparam int SH_W  = ACC_W - Y_SHIFT;

	logic                      mac_v_s1, upd_v_s1, prod_v_s2;
	logic [AW-1:0]             upd_idx_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DATA_W-1:0]  d_q, y_q, e_q;
	logic signed [DELTA_W-1:0] delta_q;

	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [SH_W-1:0]    acc_sh;
	logic [SH_W-DATA_W:0]      y_top;
	logic signed [DATA_W:0]    e_diff;
	logic signed [32:0]        d_prod, d_rnd;
	logic signed [COEF_W+1:0]  c_ext, d_ext, c_sum;
	logic [2:0]                c_top;

	assign mac_busy = mac_v_s1 | prod_v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1  <= 1'b0;
			upd_v_s1  <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			mac_v_s1  <= ctl.mac_rd;
			upd_v_s1  <= ctl.upd_rd;
			prod_v_s2 <= mac_v_s1;
		end
	end

	always_comb begin
		acc_rnd = acc_q + {{(ACC_W-Y_SHIFT){1'b0}}, 1'b1, {(Y_SHIFT-1){1'b0}}};
		acc_sh  = acc_rnd[ACC_W-1:Y_SHIFT];
		y_top   = acc_sh[SH_W-1:DATA_W-1];
		e_diff  = {d_q[DATA_W-1], d_q} - {y_q[DATA_W-1], y_q};
		d_prod  = $signed({1'b0, step_size}) * e_q;
		d_rnd   = d_prod + 33'sd4;
		c_ext   = {{2{coef_rdata[COEF_W-1]}}, coef_rdata};
		d_ext   = {{(COEF_W+2-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};
		// zero tap counts as positive
		c_sum   = samp_rdata[DATA_W-1] ? c_ext - d_ext : c_ext + d_ext;
		c_top   = c_sum[COEF_W+1:COEF_W-1];
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			d_q <= desired;
		end
		if (mac_v_s1) begin
			prod_s2 <= $signed(samp_rdata) * $signed(coef_rdata);
		end
		if (ctl.start) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
		if (ctl.fin_y) begin
			if ((&y_top) | ~(|y_top)) begin
				y_q <= acc_sh[DATA_W-1:0];
			end else begin
				y_q <= acc_sh[SH_W-1] ? DATA_MIN : DATA_MAX;
			end
		end
		if (ctl.fin_e) begin
			if (e_diff[DATA_W] == e_diff[DATA_W-1]) begin
				e_q <= e_diff[DATA_W-1:0];
			end else begin
				e_q <= e_diff[DATA_W] ? DATA_MIN : DATA_MAX;
			end
		end
		if (ctl.fin_d) begin
			delta_q <= d_rnd[32:3];
		end
		if (ctl.upd_rd) begin
			upd_idx_s1 <= rd_idx;
		end
		if (ctl.load_out) begin
			error_out  <= e_q;
			filter_out <= y_q;
		end
	end

	assign coef_we    = upd_v_s1;
	assign coef_waddr = upd_idx_s1;
	always_comb begin
		if ((&c_top) | ~(|c_top)) begin
			coef_wdata = c_sum[COEF_W-1:0];
		end else begin
			coef_wdata = c_sum[COEF_W+1] ? COEF_MIN : COEF_MAX;
		end
	end

endmodule

// ===== hdl/sdl_ctrl.sv =====
// Sequencer: clearing pass, delay-line pointer, tap addressing and handshakes.
`timescale 1ns / 1ps

module sdl_ctrl
	import sdl_pkg::*;
#(
	parameter int TAPS = TAPS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [DATA_W-1:0]                   sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                mac_busy,
	output dp_ctl_t                             ctl,
	output logic                                clearing,
	output logic                                samp_we,
	output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] samp_waddr,
	output logic [DATA_W-1:0]                   samp_wdata,
	output logic                                rd_en,
	output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] tap_addr,
	output logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] idx
);

	localparam int AW = TAPS > 1 ? $clog2(TAPS) : 1;
	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

	state_t        state_q, state_d;
	logic [AW-1:0] head_q, idx_q, tap_q;
	logic [AW-1:0] new_head, idx_next, tap_next;
	logic          out_valid_q, accept, last;

	assign accept   = in_valid & in_ready;
	assign last     = idx_q == LAST;
	assign new_head = (head_q == '0) ? LAST : head_q - 1'b1;
	assign idx_next = last ? '0 : idx_q + 1'b1;
	assign tap_next = (tap_q == LAST) ? '0 : tap_q + 1'b1;

	assign out_valid  = out_valid_q;
	assign tap_addr   = tap_q;
	assign idx        = idx_q;
	assign samp_we    = clearing | accept;
	assign samp_waddr = clearing ? idx_q : new_head;
	assign samp_wdata = clearing ? '0 : sample_in;
	assign rd_en      = ctl.mac_rd | ctl.upd_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		clearing = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				if (last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				ctl.start = in_valid;
				if (in_valid) state_d = ST_MAC;
			end
			ST_MAC: begin
				ctl.mac_rd = 1'b1;
				if (last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_busy) state_d = ST_FIN_Y;
			end
			ST_FIN_Y: begin
				ctl.fin_y = 1'b1;
				state_d   = ST_FIN_E;
			end
			ST_FIN_E: begin
				ctl.fin_e = 1'b1;
				state_d   = ST_FIN_D;
			end
			ST_FIN_D: begin
				ctl.fin_d = 1'b1;
				state_d   = ST_UPD;
			end
			ST_UPD: begin
				ctl.upd_rd = 1'b1;
				if (last) state_d = ST_UPD_END;
			end
			ST_UPD_END: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			idx_q       <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing || ctl.mac_rd || ctl.upd_rd) begin
				idx_q <= idx_next;
			end
			if (ctl.mac_rd || ctl.upd_rd) begin
				tap_q <= tap_next;
			end
			if (accept) begin
				head_q <= new_head;
				tap_q  <= new_head;
				idx_q  <= '0;
			end
			if (ctl.fin_d) begin
				tap_q <= head_q;
				idx_q <= '0;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/sign_data_lms_filter.sv =====
// Top level of the sign-data LMS adaptive FIR filter.
`timescale 1ns / 1ps

// Sign-data LMS adaptive FIR filter with TAPS taps. Delay line and Q4.28
// coefficients live in two single-read RAMs and are swept by one shared
// 16x32 multiply-accumulate unit: one pass of TAPS reads forms y, then a
// second pass of TAPS read-modify-writes adapts the coefficients. The result
// of a beat reaches the output register after those two RAM sweeps, once that
// register is empty or being drained, and no new beat is taken before then.
// The next beat is taken once the result is in the output register, even if
// that register has not been drained. After reset a clearing pass zeroes both
// RAMs before the first beat is taken; step_size writes are accepted at any
// time but belong in idle periods.

module sign_data_lms_filter
	import sdl_pkg::*;
#(
	parameter int TAPS = TAPS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [STEP_W-1:0]        cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample_in,
	input  logic signed [DATA_W-1:0] desired,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] error_out,
	output logic signed [DATA_W-1:0] filter_out
);

	localparam int AW = TAPS > 1 ? $clog2(TAPS) : 1;

	logic [STEP_W-1:0] step_size_q;
	dp_ctl_t           ctl;
	logic              clearing, mac_busy, rd_en;
	logic              samp_we, coef_we_dp, coef_we;
	logic [AW-1:0]     samp_waddr, tap_addr, idx, coef_waddr_dp, coef_waddr;
	logic [DATA_W-1:0] samp_wdata, samp_rdata;
	logic [COEF_W-1:0] coef_wdata_dp, coef_wdata, coef_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_RESET;
		end else if (cfg_wr_en) begin
			step_size_q <= cfg_wr_data;
		end
	end

	sdl_ctrl #(.TAPS(TAPS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mac_busy   (mac_busy),
		.ctl        (ctl),
		.clearing   (clearing),
		.samp_we    (samp_we),
		.samp_waddr (samp_waddr),
		.samp_wdata (samp_wdata),
		.rd_en      (rd_en),
		.tap_addr   (tap_addr),
		.idx        (idx)
	);

	assign coef_we    = clearing | coef_we_dp;
	assign coef_waddr = clearing ? idx : coef_waddr_dp;
	assign coef_wdata = clearing ? '0 : coef_wdata_dp;

	sdl_ram #(.WIDTH(DATA_W), .DEPTH(TAPS)) u_delay_ram (
		.clk   (clk),
		.we    (samp_we),
		.waddr (samp_waddr),
		.wdata (samp_wdata),
		.re    (rd_en),
		.raddr (tap_addr),
		.rdata (samp_rdata)
	);

	sdl_ram #(.WIDTH(COEF_W), .DEPTH(TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.re    (rd_en),
		.raddr (idx),
		.rdata (coef_rdata)
	);

	sdl_dp #(.TAPS(TAPS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.desired    (desired),
		.step_size  (step_size_q),
		.samp_rdata (samp_rdata),
		.coef_rdata (coef_rdata),
		.rd_idx     (idx),
		.mac_busy   (mac_busy),
		.coef_we    (coef_we_dp),
		.coef_waddr (coef_waddr_dp),
		.coef_wdata (coef_wdata_dp),
		.error_out  (error_out),
		.filter_out (filter_out)
	);

endmodule

// ===== hdl/sdl_checker.sv =====
// Port-level assertions for the sign-data LMS filter, bound to the top level.
`timescale 1ns / 1ps

module sdl_checker
	import sdl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] error_out,
	input logic [DATA_W-1:0] filter_out
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(error_out) && $stable(filter_out))
		else $error("result beat changed while stalled");

	// one beat in flight at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a beat is in flight");

	// a result never appears in the cycle after an input beat
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result without processing time");

endmodule

bind sign_data_lms_filter sdl_checker u_sdl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.error_out  (error_out),
	.filter_out (filter_out)
);

// ===== tb/tb_sign_data_lms_filter.sv =====
// Self-checking testbench for the sign-data LMS filter: directed table, then random beats.
`timescale 1ns / 1ps

module tb_sign_data_lms_filter;
	import sdl_pkg::*;

	localparam int     TAPS        = TAPS_DEFAULT;
	localparam int     RAND_BEATS  = 528;
	localparam int     HOLD_CYCLES = 800;
	localparam int     TAIL_CYCLES = 4 * (2 * TAPS + 9);
	localparam int     CYCLE_LIMIT = 800000;
	localparam int     MAX_REPORTS = 40;
	localparam longint Y_HI        = 32767;
	localparam longint Y_LO        = -32768;
	localparam longint C_HI        = 64'sd2147483647;
	localparam longint C_LO        = -64'sd2147483648;

	typedef logic signed [DATA_W-1:0] smp_t;

	typedef struct packed {
		smp_t e;
		smp_t y;
	} lms_out_t;

	typedef struct {
		logic [STEP_W-1:0] mu;
		smp_t              x;
		smp_t              d;
		bit                typed;
		lms_out_t          res;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [STEP_W-1:0] cfg_wr_data;
	logic              in_valid;
	logic              in_ready;
	smp_t              sample_in;
	smp_t              desired;
	logic              out_valid;
	logic              out_ready;
	smp_t              error_out;
	smp_t              filter_out;

	// beat-side tag: a typed-in result replaces the predicted one
	logic     beat_typed;
	lms_out_t beat_typed_res;

	smp_t                     dline [TAPS];
	logic signed [COEF_W-1:0] coef [TAPS];
	logic [STEP_W-1:0]        step_mu;
	lms_out_t                 out_due_q [$];
	dir_row_t                 dir_tab [$];
	smp_t                     plant_hist [4];

	int mismatches   = 0;
	int reports      = 0;
	int results_seen = 0;
	int beats_sent   = 0;
	int step_writes  = 0;
	int sat_outputs  = 0;
	int in_stalls    = 0;
	int cycle_count  = 0;
	int snd_calm     = 0;

	sign_data_lms_filter #(
		.TAPS(TAPS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.desired    (desired),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.error_out  (error_out),
		.filter_out (filter_out)
	);

	always #5 clk = ~clk;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	// shift, dot product, then sign-data coefficient update
	function automatic lms_out_t lms_advance(input smp_t x, input smp_t d);
		longint   acc;
		longint   y;
		longint   e;
		longint   delta;
		longint   c;
		lms_out_t r;
		for (int i = TAPS - 1; i > 0; i--)
			dline[i] = dline[i-1];
		dline[0] = x;
		acc = 0;
		for (int i = 0; i < TAPS; i++)
			acc += longint'(dline[i]) * longint'(coef[i]);
		y = clamp((acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT, Y_LO, Y_HI);
		e = clamp(longint'(d) - y, Y_LO, Y_HI);
		// Q1.31 product down to Q4.28, round half up
		delta = (longint'(step_mu) * e + 4) >>> 3;
		for (int i = 0; i < TAPS; i++) begin
			c = longint'(coef[i]) + ((dline[i] >= 0) ? delta : -delta);
			coef[i] = COEF_W'(clamp(c, C_LO, C_HI));
		end
		r.e = smp_t'(e);
		r.y = smp_t'(y);
		return r;
	endfunction

	function automatic void note_bad(input string what, input int want, input int got);
		mismatches++;
		if (reports < MAX_REPORTS)
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		reports++;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	function automatic smp_t rand_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return smp_t'($urandom);
		if (r < 85) begin
			case ($urandom_range(0, 4))
				0: return DATA_MIN;
				1: return DATA_MAX;
				2: return '0;
				3: return -16'sd1;
				default: return 16'sd1;
			endcase
		end
		return smp_t'($urandom_range(0, 64)) - 16'sd32;
	endfunction

	function automatic void add_row(input logic [STEP_W-1:0] mu, input smp_t x, input smp_t d,
			input bit typed = 1'b0, input smp_t e = '0, input smp_t y = '0);
		dir_row_t row;
		row.mu    = mu;
		row.x     = x;
		row.d     = d;
		row.typed = typed;
		row.res.e = e;
		row.res.y = y;
		dir_tab.push_back(row);
	endfunction

	task automatic send_beat(input smp_t x, input smp_t d, input bit typed, input lms_out_t res);
		int gap;
		if (snd_calm > 0) begin
			snd_calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 99) < 3)
				snd_calm = $urandom_range(20, 60);
			gap = gap_len();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		sample_in      <= x;
		desired        <= d;
		beat_typed     <= typed;
		beat_typed_res <= res;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (out_due_q.size() != 0);
	endtask

	task automatic set_step(input logic [STEP_W-1:0] mu);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mu;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		step_mu = mu;
		step_writes++;
	endtask

	// mostly an unknown-plant identification: d follows a delayed, halved x plus noise
	task automatic rand_phase(input logic [STEP_W-1:0] mu, input int n);
		smp_t     x;
		smp_t     d;
		lms_out_t none;
		none = '0;
		if (mu != step_mu)
			set_step(mu);
		repeat (n) begin
			x = rand_sample();
			if ($urandom_range(0, 9) < 7)
				d = (plant_hist[2] >>> 1) + smp_t'($urandom_range(0, 32)) - 16'sd16;
			else
				d = rand_sample();
			for (int i = 3; i > 0; i--)
				plant_hist[i] = plant_hist[i-1];
			plant_hist[0] = x;
			send_beat(x, d, 1'b0, none);
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		lms_out_t got;
		lms_out_t want;
		lms_out_t pred;
		if (arst_n && out_valid && out_ready) begin
			got.e = error_out;
			got.y = filter_out;
			results_seen++;
			if (out_due_q.size() == 0) begin
				mismatches++;
				if (reports < MAX_REPORTS)
					$display("%0t: beat with nothing pending, expected none, got e=%0d y=%0d",
						$time, got.e, got.y);
				reports++;
			end else begin
				want = out_due_q.pop_front();
				if (got.e !== want.e)
					note_bad("error_out", want.e, got.e);
				if (got.y !== want.y)
					note_bad("filter_out", want.y, got.y);
			end
		end
		if (arst_n && in_valid && !in_ready)
			in_stalls++;
		if (arst_n && in_valid && in_ready) begin
			pred = lms_advance(sample_in, desired);
			if (pred.y == DATA_MAX || pred.y == DATA_MIN)
				sat_outputs++;
			out_due_q.push_back(beat_typed ? beat_typed_res : pred);
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin : sink
		int gap;
		int calm;
		bit held;
		gap  = 0;
		calm = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 150) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 99) < 4)
					calm = $urandom_range(30, 150);
				else
					gap = gap_len();
			end
		end
	end

	initial begin
		logic [STEP_W-1:0] mus [6];
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		in_valid       <= 1'b0;
		sample_in      <= '0;
		desired        <= '0;
		beat_typed     <= 1'b0;
		beat_typed_res <= '0;
		step_mu = STEP_RESET;
		foreach (dline[i]) begin
			dline[i] = '0;
			coef[i]  = '0;
		end
		foreach (plant_hist[i])
			plant_hist[i] = '0;

		// zero delay line after reset: y stays 0 and e = d while coefficients ramp to the rail
		add_row(STEP_RESET, '0, DATA_MAX, 1'b1, DATA_MAX, '0);
		repeat (9)
			add_row(16'hFFFF, '0, DATA_MAX, 1'b1, DATA_MAX, '0);
		// saturated coefficients drive y and e both to clip
		add_row(16'hFFFF, DATA_MAX, DATA_MIN, 1'b1, DATA_MIN, DATA_MAX);
		add_row(16'hFFFF, DATA_MIN, DATA_MAX);
		add_row(16'hFFFF, DATA_MIN, DATA_MIN);
		add_row(16'h0000, 16'sd1234, -16'sd4321);
		add_row(16'h0000, -16'sd1, 16'sd1);
		add_row(16'h0000, DATA_MIN, DATA_MIN);
		add_row(STEP_RESET, 16'sh5555, 16'shAAAA);
		add_row(STEP_RESET, 16'shAAAA, 16'sh5555);
		add_row(STEP_RESET, DATA_MAX, '0);
		add_row(STEP_RESET, '0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[k]) begin
			if (dir_tab[k].mu != step_mu)
				set_step(dir_tab[k].mu);
			send_beat(dir_tab[k].x, dir_tab[k].d, dir_tab[k].typed, dir_tab[k].res);
		end

		mus = '{16'hFFFF, 16'h0000, 16'h0001, STEP_W'($urandom), STEP_RESET,
			STEP_W'($urandom_range(1, 4096))};
		foreach (mus[p])
			rand_phase(mus[p], RAND_BEATS / 6);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (out_due_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, out_due_q.size());
			mismatches += out_due_q.size();
		end

		$display("Checked %0d results from %0d beats (%0d directed), over %0d step_size writes.",
			results_seen, beats_sent, dir_tab.size(), step_writes);
		$display("Clipped outputs: %0d; input back-pressure cycles: %0d; mismatches: %0d.",
			sat_outputs, in_stalls, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
